// ===== sv/max_subarray_sum_len_multiple_k_core_assert.svh =====
// Assertion macros for the core; empty when SYNTH is defined.
`ifndef MAX_SUBARRAY_SUM_LEN_MULTIPLE_K_CORE_ASSERT_SVH
`define MAX_SUBARRAY_SUM_LEN_MULTIPLE_K_CORE_ASSERT_SVH
`ifndef SYNTH
`define MSSK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MSSK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MSSK_ASSERT(lbl, prop, msg)
`define MSSK_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/mssk_pkg.sv =====
`timescale 1ns / 1ps

package mssk_pkg;

    localparam int MAX_K_DEF = 1024;
    localparam int VALUE_W   = 32;
    localparam int SUM_W     = 64;
    localparam int CFG_W     = 11;
    localparam int OUT_DEPTH = 4;

    localparam logic [CFG_W-1:0] CFG_K_RST = CFG_W'(1);
    localparam logic [SUM_W-1:0] SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic [SUM_W-1:0] best_sum;
        logic             found;
    } res_t;

endpackage

// ===== sv/mssk_min_ram.sv =====
`timescale 1ns / 1ps

module mssk_min_ram #(
    parameter int DEPTH = mssk_pkg::MAX_K_DEF,
    parameter int AW    = 10,
    parameter int DW    = mssk_pkg::SUM_W
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // read-before-write on a same-address collision
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/mssk_ofifo.sv =====
`timescale 1ns / 1ps

module mssk_ofifo #(
    parameter int DEPTH = mssk_pkg::OUT_DEPTH,
    parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mssk_pkg::res_t push_data,
    input  logic           pop,
    output mssk_pkg::res_t head,
    output logic           not_empty,
    output logic [CW-1:0]  count
);

    mssk_pkg::res_t store [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_pop;

    assign not_empty = (cnt_reg != '0);
    assign do_pop    = pop && not_empty;
    assign head      = store[rd_ptr_reg];
    assign count     = cnt_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/max_subarray_sum_len_multiple_k_core.sv =====
`timescale 1ns / 1ps
// A tlast word's result goes through stage 1, stage 2 and the output buffer to m_axis.
// Throughput: 1 input word per cycle while s_axis_tready is high; one table read and
// write-back per word, with a one-entry bypass for same-residue back-to-back words.
// Results queue in a 4-entry output buffer; s_axis_tready drops only when it could fill.
// Reset (async, rst_n low): k = 1, sums and residue cleared; the min table is not swept,
// entries beyond the fill count read as empty. State also clears after each tlast word.
`include "max_subarray_sum_len_multiple_k_core_assert.svh"

module max_subarray_sum_len_multiple_k_core #(
    parameter int MAX_K = mssk_pkg::MAX_K_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [mssk_pkg::CFG_W-1:0] cfg_wdata,     // divisor_k
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [31:0]                s_axis_tdata,  // [31:0] value
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [63:0]                m_axis_tdata,  // [63:0] best_sum
    output logic [0:0]                 m_axis_tuser   // [0] found
);

    localparam int RW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KW  = $clog2(MAX_K + 1);
    localparam int SW  = mssk_pkg::SUM_W;
    localparam int VW  = mssk_pkg::VALUE_W;
    localparam int FCW = $clog2(mssk_pkg::OUT_DEPTH + 1);
    localparam int CRW = FCW + 1;

    // config
    logic [mssk_pkg::CFG_W-1:0] k_reg;
    logic [KW-1:0]              k_eff;

    // stage 0
    logic          accept;
    logic [SW-1:0] prefix_reg, prefix_next, prefix_sum;
    logic [RW-1:0] residue_reg, residue_next, res_new;
    logic [KW-1:0] res_inc;

    // stage 1
    logic          s1_valid_reg, s1_last_reg;
    logic [SW-1:0] s1_prefix_reg;
    logic [RW-1:0] s1_res_reg;
    logic          byp_hit_reg;
    logic [SW-1:0] byp_data_reg;
    logic [RW-1:0] fill_reg, fill_next;
    logic          e0_reg, e0_next;
    logic [SW-1:0] ram_rdata, min_raw, min_v, new_min, cand;
    logic          ent_valid, lower;

    // stage 2
    logic          s2_valid_reg, s2_last_reg, s2_hit_reg;
    logic [SW-1:0] s2_cand_reg;
    logic [SW-1:0] best_reg, best_next, best_after;
    logic          any_reg, any_next, any_after, upd;

    // output
    mssk_pkg::res_t push_res, head_res;
    logic           push, fifo_ne;
    logic [FCW-1:0] fifo_cnt;
    logic [CRW-1:0] inflight;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= mssk_pkg::CFG_K_RST;
        end
        else if (cfg_we)
        begin
            k_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (k_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (32'(k_reg) > 32'(MAX_K))
        begin
            k_eff = KW'(MAX_K);
        end
        else
        begin
            k_eff = KW'(k_reg);
        end
    end

    // credit check against the output buffer
    assign inflight = CRW'(fifo_cnt) + CRW'(s1_valid_reg && s1_last_reg)
                    + CRW'(s2_valid_reg && s2_last_reg);
    assign s_axis_tready = (inflight < CRW'(mssk_pkg::OUT_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign prefix_sum = prefix_reg + {{(SW-VW){s_axis_tdata[VW-1]}}, s_axis_tdata};
    assign res_inc    = KW'(residue_reg) + KW'(1);
    assign res_new    = (res_inc >= k_eff) ? '0 : RW'(res_inc);

    always_comb
    begin
        prefix_next  = prefix_reg;
        residue_next = residue_reg;
        if (accept)
        begin
            if (s_axis_tlast)
            begin
                prefix_next  = '0;
                residue_next = '0;
            end
            else
            begin
                prefix_next  = prefix_sum;
                residue_next = res_new;
            end
        end
    end

    mssk_min_ram #(
        .DEPTH (MAX_K),
        .AW    (RW),
        .DW    (SW)
    ) u_min_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (res_new),
        .rd_data (ram_rdata),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_res_reg),
        .wr_data (new_min)
    );

    // stage 1: read-modify-write of the min table
    assign min_raw   = byp_hit_reg ? byp_data_reg : ram_rdata;
    assign min_v     = (s1_res_reg == '0 && !e0_reg) ? '0 : min_raw;
    assign ent_valid = (s1_res_reg == '0) || (s1_res_reg <= fill_reg);
    assign cand      = s1_prefix_reg - min_v;
    assign lower     = !ent_valid || ($signed(s1_prefix_reg) < $signed(min_v));
    assign new_min   = lower ? s1_prefix_reg : min_v;

    always_comb
    begin
        fill_next = fill_reg;
        e0_next   = e0_reg;
        if (s1_valid_reg)
        begin
            if (s1_last_reg)
            begin
                fill_next = '0;
                e0_next   = 1'b0;
            end
            else
            begin
                if (s1_res_reg > fill_reg)
                begin
                    fill_next = s1_res_reg;
                end
                if (s1_res_reg == '0)
                begin
                    e0_next = 1'b1;
                end
            end
        end
    end

    // stage 2: running best
    assign upd        = s2_hit_reg && (!any_reg || ($signed(best_reg) < $signed(s2_cand_reg)));
    assign best_after = upd ? s2_cand_reg : best_reg;
    assign any_after  = any_reg || s2_hit_reg;
    assign push       = s2_valid_reg && s2_last_reg;

    always_comb
    begin
        best_next = best_reg;
        any_next  = any_reg;
        if (s2_valid_reg)
        begin
            if (s2_last_reg)
            begin
                best_next = mssk_pkg::SUM_MIN;
                any_next  = 1'b0;
            end
            else
            begin
                best_next = best_after;
                any_next  = any_after;
            end
        end
    end

    assign push_res.best_sum = any_after ? best_after : mssk_pkg::SUM_MIN;
    assign push_res.found    = any_after;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg   <= '0;
            residue_reg  <= '0;
            s1_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
            fill_reg     <= '0;
            e0_reg       <= 1'b0;
            s2_valid_reg <= 1'b0;
            best_reg     <= mssk_pkg::SUM_MIN;
            any_reg      <= 1'b0;
        end
        else
        begin
            prefix_reg   <= prefix_next;
            residue_reg  <= residue_next;
            s1_valid_reg <= accept;
            byp_hit_reg  <= accept && s1_valid_reg && (s1_res_reg == res_new);
            fill_reg     <= fill_next;
            e0_reg       <= e0_next;
            s2_valid_reg <= s1_valid_reg;
            best_reg     <= best_next;
            any_reg      <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_prefix_reg <= prefix_sum;
            s1_res_reg    <= res_new;
            s1_last_reg   <= s_axis_tlast;
        end
        byp_data_reg <= new_min;
        if (s1_valid_reg)
        begin
            s2_cand_reg <= cand;
            s2_hit_reg  <= ent_valid;
            s2_last_reg <= s1_last_reg;
        end
    end

    mssk_ofifo #(
        .DEPTH (mssk_pkg::OUT_DEPTH)
    ) u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_res),
        .pop       (m_axis_tready),
        .head      (head_res),
        .not_empty (fifo_ne),
        .count     (fifo_cnt)
    );

    assign m_axis_tvalid   = fifo_ne;
    assign m_axis_tdata    = head_res.best_sum;
    assign m_axis_tuser[0] = head_res.found;

    `MSSK_ASSERT(a_no_overflow, !(push && fifo_cnt == FCW'(mssk_pkg::OUT_DEPTH) && !m_axis_tready), "result buffer overflow")
    `MSSK_ASSERT_NEXT(a_byp_follows, !s1_valid_reg, !byp_hit_reg, "bypass hit without a word ahead")
    `MSSK_ASSERT_NEXT(a_seq_clear, s1_valid_reg && s1_last_reg, fill_reg == '0 && !e0_reg, "table state not cleared")
    `MSSK_ASSERT(a_stall_cause, s_axis_tready || fifo_ne || push, "input stalled with no pending result")

endmodule
